>>> hdl/rpm_pkg.sv
// shared types and constants of the randomized prim maze carver
package rpm_pkg;

    localparam int MAX_CELLS_DEF = 1024;
    localparam int MAX_SIDE_DEF  = 32;

    localparam int CFG_W      = 6;
    localparam int PICK_W     = 31;
    localparam int OUT_CELL_W = 10;
    localparam int DIV_W      = 32;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [CFG_W-1:0] SIDE_RESET = 6'd32;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLAMP,
        S_PROD,
        S_CHK,
        S_HDIV,
        S_HWAIT,
        S_CLEAR,
        S_PDIV,
        S_PWAIT,
        S_FREAD,
        S_FGET,
        S_XDIV,
        S_XWAIT,
        S_MREAD,
        S_MGET,
        S_SCAN,
        S_PUSH,
        S_LDIV,
        S_LWAIT,
        S_MARK,
        S_SHIFT,
        S_FIN
    } t_state;

endpackage

>>> hdl/rpm_ram.sv
// single write port, single registered read port memory
module rpm_ram #(
    parameter int W = 10,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rpm_div.sv
// restoring divider, one quotient bit per cycle
module rpm_div #(
    parameter int DVW = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rpm_pkg::DIV_W-1:0] i_dividend,
    input  logic [DVW-1:0]           i_divisor,
    output logic                     o_done,
    output logic [rpm_pkg::DIV_W-1:0] o_quot,
    output logic [DVW-1:0]           o_rem
);

    localparam int CNT_W = $clog2(rpm_pkg::DIV_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [rpm_pkg::DIV_W-1:0] r_q;
    logic [DVW-1:0]            r_r;
    logic [DVW-1:0]            r_d;
    logic [DVW:0]              w_sh;
    logic                      w_ge;

    assign w_sh = {r_r, r_q[rpm_pkg::DIV_W-1]};
    assign w_ge = w_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(rpm_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[rpm_pkg::DIV_W-2:0], w_ge};
            r_r <= w_ge ? DVW'(w_sh - {1'b0, r_d}) : DVW'(w_sh);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

>>> hdl/random_prim_maze_carver.sv
// top level of the randomized prim maze carver
//
// Carves a maze one request at a time. A start request (kind 0) latches the
// grid size, clears the maze store, picks the start cell as rand_pick modulo
// the cell count and lists its neighbours; the clearing pass clears one entry
// a cycle. A step request (kind 1) runs up to three divisions on the shared
// restoring divider (entry pick, cell to x/y, and a link pick when the cell
// has an in-maze neighbour), maze-store reads for the four neighbours, a scan
// of the whole frontier list for duplicates and a shift of the entries after
// the picked one, both one entry a cycle through the frontier memory's single
// read port. Input stall is high from an accepted request until its result is
// in the output register; the result register lets the next request in while
// a result still waits. Registers (APB, byte address 0 width, 4 height) take
// effect at the next start request.
module random_prim_maze_carver #(
    parameter int MAX_CELLS = rpm_pkg::MAX_CELLS_DEF,
    parameter int MAX_SIDE  = rpm_pkg::MAX_SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [rpm_pkg::PICK_W-1:0]     i_rand_pick,
    input  logic [rpm_pkg::PICK_W-1:0]     i_rand_link,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rpm_pkg::OUT_CELL_W-1:0] o_from_cell,
    output logic [rpm_pkg::OUT_CELL_W-1:0] o_to_cell,
    output logic [1:0]                     o_direction,
    output logic                           o_is_start,
    output logic                           o_last,
    output logic                           o_error,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rpm_pkg::PADDR_W-1:0]    paddr,
    input  logic [rpm_pkg::PDATA_W-1:0]    pwdata,
    output logic [rpm_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int CW  = $clog2(MAX_CELLS);
    localparam int LW  = $clog2(MAX_CELLS + 1);
    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int PW  = 2 * SW;
    localparam int OW  = rpm_pkg::OUT_CELL_W;
    localparam int CFW = rpm_pkg::CFG_W;

    rpm_pkg::t_state r_state, n_state;

    // configuration and latched geometry
    logic [CFW-1:0] r_gw, r_gh;
    logic [SW-1:0]  r_cw, r_ch;
    logic [PW-1:0]  r_prod;
    logic [LW-1:0]  r_cells;

    // request and frontier bookkeeping
    logic                       r_kind;
    logic [rpm_pkg::PICK_W-1:0] r_pick, r_link;
    logic [LW-1:0]              r_len;
    logic [CW-1:0]              r_idx, r_cell;
    logic [CW-1:0]              r_nb [4];
    logic [3:0]                 r_nbv, r_inm, r_lst;
    logic [1:0]                 r_j;
    logic [LW-1:0]              r_sa;
    logic [CW-1:0]              r_wa;
    logic                       r_pend;

    // staged result and output register
    logic [CW-1:0] r_from, r_to;
    logic [1:0]    r_dir;
    logic          r_isst, r_err;
    logic          r_ovalid;
    logic [OW-1:0] r_o_from, r_o_to;
    logic [1:0]    r_o_dir;
    logic          r_o_isst, r_o_last, r_o_err;

    logic w_in_acc, w_out_acc, w_load, w_cfg_wr;

    // shared divider
    logic                      div_start, div_done;
    logic [rpm_pkg::DIV_W-1:0] div_dvd, div_quot;
    logic [LW-1:0]             div_dvs, div_rem;

    // memories
    logic          f_we, m_we;
    logic [CW-1:0] f_waddr, f_raddr, m_waddr, m_raddr;
    logic [CW-1:0] f_wdata, f_rdata;
    logic          m_wdata, m_rdata;

    // neighbour helpers
    logic [SW-1:0] w_x, w_y;
    logic [2:0]    w_nc;
    logic [1:0]    w_sel;
    logic [2:0]    w_cnt;
    logic          w_push;
    logic [SW-1:0] w_cwc, w_chc;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_ovalid && !i_out_stall;
    assign w_load    = (r_state == rpm_pkg::S_FIN) && (!r_ovalid || !i_out_stall);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    assign o_in_stall = (r_state != rpm_pkg::S_IDLE);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == rpm_pkg::REG_HEIGHT) ?
                        rpm_pkg::PDATA_W'(r_gh) : rpm_pkg::PDATA_W'(r_gw);

    // side clamping: zero becomes one, above the limit becomes the limit
    always_comb begin
        if (r_gw == '0) w_cwc = SW'(1);
        else if (32'(r_gw) > 32'(MAX_SIDE)) w_cwc = SW'(MAX_SIDE);
        else w_cwc = SW'(r_gw);
        if (r_gh == '0) w_chc = SW'(1);
        else if (32'(r_gh) > 32'(MAX_SIDE)) w_chc = SW'(MAX_SIDE);
        else w_chc = SW'(r_gh);
    end

    assign w_x = SW'(div_rem);
    assign w_y = SW'(div_quot);

    // in-maze neighbour count and the one picked by the link remainder
    always_comb begin
        w_nc  = '0;
        w_cnt = '0;
        w_sel = rpm_pkg::DIR_LEFT;
        for (int j = 0; j < 4; j++) begin
            if (r_nbv[j] && r_inm[j]) begin
                w_nc = w_nc + 3'd1;
                if (w_cnt == {1'b0, div_rem[1:0]}) w_sel = 2'(j);
                w_cnt = w_cnt + 3'd1;
            end
        end
    end

    assign w_push = r_nbv[r_j] && (r_len < LW'(MAX_CELLS)) &&
                    ((r_kind == rpm_pkg::KIND_START) || (!r_inm[r_j] && !r_lst[r_j]));

    rpm_div #(.DVW(LW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    rpm_ram #(.W(CW), .D(MAX_CELLS)) u_frontier (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    rpm_ram #(.W(1), .D(MAX_CELLS)) u_in_maze (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: next state, divider operands and memory ports
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = LW'(1);
        f_we      = 1'b0;
        f_waddr   = r_wa;
        f_wdata   = f_rdata;
        f_raddr   = r_sa[CW-1:0];
        m_we      = 1'b0;
        m_waddr   = r_cell;
        m_wdata   = 1'b0;
        m_raddr   = r_nb[r_j];
        unique case (r_state)
            rpm_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_kind == rpm_pkg::KIND_START) n_state = rpm_pkg::S_CLAMP;
                    else if (r_len == '0) n_state = rpm_pkg::S_FIN;
                    else n_state = rpm_pkg::S_PDIV;
                end
            end
            rpm_pkg::S_CLAMP: n_state = rpm_pkg::S_PROD;
            rpm_pkg::S_PROD:  n_state = rpm_pkg::S_CHK;
            rpm_pkg::S_CHK: begin
                if (32'(r_prod) > 32'(MAX_CELLS)) n_state = rpm_pkg::S_HDIV;
                else n_state = rpm_pkg::S_CLEAR;
            end
            rpm_pkg::S_HDIV: begin
                div_start = 1'b1;
                div_dvd   = rpm_pkg::DIV_W'(MAX_CELLS);
                div_dvs   = LW'(r_cw);
                n_state   = rpm_pkg::S_HWAIT;
            end
            rpm_pkg::S_HWAIT: if (div_done) n_state = rpm_pkg::S_PROD;
            rpm_pkg::S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_sa[CW-1:0];
                m_wdata = 1'b0;
                if (r_sa == r_cells - 1'b1) n_state = rpm_pkg::S_PDIV;
            end
            rpm_pkg::S_PDIV: begin
                div_start = 1'b1;
                div_dvd   = rpm_pkg::DIV_W'(r_pick);
                div_dvs   = (r_kind == rpm_pkg::KIND_START) ? r_cells : r_len;
                n_state   = rpm_pkg::S_PWAIT;
            end
            rpm_pkg::S_PWAIT: begin
                if (div_done) begin
                    if (r_kind == rpm_pkg::KIND_START) begin
                        m_we    = 1'b1;
                        m_waddr = CW'(div_rem);
                        m_wdata = 1'b1;
                        n_state = rpm_pkg::S_XDIV;
                    end else begin
                        n_state = rpm_pkg::S_FREAD;
                    end
                end
            end
            rpm_pkg::S_FREAD: begin
                f_raddr = r_idx;
                n_state = rpm_pkg::S_FGET;
            end
            rpm_pkg::S_FGET: n_state = rpm_pkg::S_XDIV;
            rpm_pkg::S_XDIV: begin
                div_start = 1'b1;
                div_dvd   = rpm_pkg::DIV_W'(r_cell);
                div_dvs   = LW'(r_cw);
                n_state   = rpm_pkg::S_XWAIT;
            end
            rpm_pkg::S_XWAIT: begin
                if (div_done) begin
                    if (r_kind == rpm_pkg::KIND_START) n_state = rpm_pkg::S_PUSH;
                    else n_state = rpm_pkg::S_MREAD;
                end
            end
            rpm_pkg::S_MREAD: n_state = rpm_pkg::S_MGET;
            rpm_pkg::S_MGET: begin
                if (r_j == 2'd3) n_state = rpm_pkg::S_SCAN;
                else n_state = rpm_pkg::S_MREAD;
            end
            rpm_pkg::S_SCAN: begin
                if (!r_pend && (r_sa >= r_len)) n_state = rpm_pkg::S_PUSH;
            end
            rpm_pkg::S_PUSH: begin
                f_we    = w_push;
                f_waddr = r_len[CW-1:0];
                f_wdata = r_nb[r_j];
                if (r_j == 2'd3) begin
                    if (r_kind == rpm_pkg::KIND_START) n_state = rpm_pkg::S_FIN;
                    else if (w_nc == '0) n_state = rpm_pkg::S_MARK;
                    else n_state = rpm_pkg::S_LDIV;
                end
            end
            rpm_pkg::S_LDIV: begin
                div_start = 1'b1;
                div_dvd   = rpm_pkg::DIV_W'(r_link);
                div_dvs   = LW'(w_nc);
                n_state   = rpm_pkg::S_LWAIT;
            end
            rpm_pkg::S_LWAIT: if (div_done) n_state = rpm_pkg::S_MARK;
            rpm_pkg::S_MARK: begin
                m_we    = 1'b1;
                m_waddr = r_cell;
                m_wdata = 1'b1;
                n_state = rpm_pkg::S_SHIFT;
            end
            rpm_pkg::S_SHIFT: begin
                f_we    = r_pend;
                f_waddr = r_wa;
                f_wdata = f_rdata;
                if (!r_pend && (r_sa >= r_len)) n_state = rpm_pkg::S_FIN;
            end
            rpm_pkg::S_FIN: if (w_load) n_state = rpm_pkg::S_IDLE;
            default: n_state = rpm_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw     <= rpm_pkg::SIDE_RESET;
            r_gh     <= rpm_pkg::SIDE_RESET;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == rpm_pkg::REG_WIDTH) r_gw <= pwdata[CFW-1:0];
                else r_gh <= pwdata[CFW-1:0];
            end
            if (r_state == rpm_pkg::S_PWAIT && div_done && r_kind == rpm_pkg::KIND_START) begin
                r_len <= '0;
            end else if (r_state == rpm_pkg::S_PUSH && w_push) begin
                r_len <= r_len + 1'b1;
            end else if (r_state == rpm_pkg::S_SHIFT && !r_pend && (r_sa >= r_len)) begin
                r_len <= r_len - 1'b1;
            end
            if (w_load) r_ovalid <= 1'b1;
            else if (w_out_acc) r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            rpm_pkg::S_IDLE: begin
                r_kind <= i_kind;
                r_pick <= i_rand_pick;
                r_link <= i_rand_link;
                // step with nothing pending
                r_from <= '0;
                r_to   <= '0;
                r_dir  <= rpm_pkg::DIR_LEFT;
                r_isst <= 1'b0;
                r_err  <= 1'b1;
            end
            rpm_pkg::S_CLAMP: begin
                r_cw <= w_cwc;
                r_ch <= w_chc;
            end
            rpm_pkg::S_PROD: r_prod <= PW'(r_cw) * PW'(r_ch);
            rpm_pkg::S_CHK: begin
                r_cells <= LW'(r_prod);
                r_sa    <= '0;
            end
            rpm_pkg::S_HWAIT: if (div_done) r_ch <= SW'(div_quot);
            rpm_pkg::S_CLEAR: r_sa <= r_sa + 1'b1;
            rpm_pkg::S_PWAIT: begin
                if (div_done) begin
                    r_cell <= CW'(div_rem);
                    r_idx  <= CW'(div_rem);
                end
            end
            rpm_pkg::S_FGET: begin
                // out-of-grid entries fall back to cell zero
                if (32'(f_rdata) >= 32'(r_cells)) r_cell <= '0;
                else r_cell <= f_rdata;
            end
            rpm_pkg::S_XWAIT: begin
                if (div_done) begin
                    r_nb[0] <= r_cell - 1'b1;
                    r_nb[1] <= r_cell + 1'b1;
                    r_nb[2] <= r_cell - CW'(r_cw);
                    r_nb[3] <= r_cell + CW'(r_cw);
                    r_nbv[0] <= (w_x != '0);
                    r_nbv[1] <= (32'(w_x) + 32'd1 < 32'(r_cw));
                    r_nbv[2] <= (w_y != '0);
                    r_nbv[3] <= (32'(w_y) + 32'd1 < 32'(r_ch));
                    r_inm  <= '0;
                    r_lst  <= '0;
                    r_j    <= '0;
                    r_sa   <= '0;
                    r_pend <= 1'b0;
                end
            end
            rpm_pkg::S_MGET: begin
                r_inm[r_j] <= m_rdata && r_nbv[r_j];
                r_j        <= r_j + 1'b1;
            end
            rpm_pkg::S_SCAN: begin
                if (r_pend) begin
                    for (int j = 0; j < 4; j++) begin
                        if (f_rdata == r_nb[j]) r_lst[j] <= 1'b1;
                    end
                end
                if (r_sa < r_len) begin
                    r_sa   <= r_sa + 1'b1;
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
            rpm_pkg::S_PUSH: begin
                r_j    <= r_j + 1'b1;
                r_from <= r_cell;
                r_err  <= 1'b0;
                r_dir  <= rpm_pkg::DIR_LEFT;
                if (r_kind == rpm_pkg::KIND_START) begin
                    r_to   <= '0;
                    r_isst <= 1'b1;
                end else begin
                    // no in-maze neighbour links the cell to itself
                    r_to   <= r_cell;
                    r_isst <= 1'b0;
                end
            end
            rpm_pkg::S_LWAIT: begin
                if (div_done) begin
                    r_to  <= r_nb[w_sel];
                    r_dir <= w_sel;
                end
            end
            rpm_pkg::S_MARK: begin
                r_sa   <= LW'(r_idx) + 1'b1;
                r_wa   <= r_idx;
                r_pend <= 1'b0;
            end
            rpm_pkg::S_SHIFT: begin
                if (r_pend) r_wa <= r_wa + 1'b1;
                if (r_sa < r_len) begin
                    r_sa   <= r_sa + 1'b1;
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_from <= OW'(r_from);
            r_o_to   <= OW'(r_to);
            r_o_dir  <= r_dir;
            r_o_isst <= r_isst;
            r_o_err  <= r_err;
            r_o_last <= (r_len == '0);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_from_cell = r_o_from;
    assign o_to_cell   = r_o_to;
    assign o_direction = r_o_dir;
    assign o_is_start  = r_o_isst;
    assign o_last      = r_o_last;
    assign o_error     = r_o_err;

endmodule

>>> hdl/rpm_checker.sv
// port-level checks of the maze carver, bound to the top level
module rpm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [rpm_pkg::OUT_CELL_W-1:0] o_from_cell,
    input logic                           o_is_start,
    input logic                           o_last,
    input logic                           o_error
);

    // an accepted request closes the input in the cycle after it
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_from_cell)))
        else $error("stalled result changed");

    // an empty-frontier step reports an empty list
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_last && !o_is_start && (o_from_cell == '0)))
        else $error("error result with wrong fields");

    // a new result appears only after some request was accepted
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work in progress");

endmodule

bind random_prim_maze_carver rpm_checker u_rpm_checker (.*);

>>> verif/tb.sv
// testbench of the randomized prim maze carver
module tb;

    localparam int NCELL = 1024;
    localparam int SIDE = 32;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_kind = rpm_pkg::KIND_START;
    logic [rpm_pkg::PICK_W-1:0] i_rand_pick = '0;
    logic [rpm_pkg::PICK_W-1:0] i_rand_link = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [rpm_pkg::OUT_CELL_W-1:0] o_from_cell, o_to_cell;
    logic [1:0] o_direction;
    logic o_is_start, o_last, o_error;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [rpm_pkg::PADDR_W-1:0] paddr = '0;
    logic [rpm_pkg::PDATA_W-1:0] pwdata = '0;
    logic [rpm_pkg::PDATA_W-1:0] prdata;
    logic pready;

    random_prim_maze_carver dut (.*);

    typedef struct packed {
        logic [rpm_pkg::OUT_CELL_W-1:0] from_cell;
        logic [rpm_pkg::OUT_CELL_W-1:0] to_cell;
        logic [1:0] direction;
        logic is_start;
        logic last;
        logic error;
    } t_carve;

    // predictor state: register copies, latched grid, maze and frontier
    int unsigned reg_w = 32, reg_h = 32;
    int unsigned grid_w = 32, grid_h = 32;
    bit maze_bit [NCELL];
    int unsigned front [NCELL];
    int unsigned front_len = 0;

    t_carve carve_q [$];
    int mismatches = 0;
    int unsigned cycle_cnt = 0;
    int send_idle_pct = 0, stall_pct = 0;
    int hold_off = 0;

    initial forever #10 i_clk = ~i_clk;

    // generous cycle limit covering the slowest steps, stalls on top
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 6000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned side_clamp(int unsigned v);
        if (v == 0) return 1;
        if (v > SIDE) return SIDE;
        return v;
    endfunction

    function automatic bit on_front(int unsigned c);
        for (int unsigned i = 0; i < front_len; i++)
            if (front[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    // neighbours in left, right, up, down order
    function automatic int unsigned nbrs(int unsigned c, output int unsigned nb[4],
                                         output logic [1:0] dr[4]);
        int unsigned x, y, n;
        x = c % grid_w;
        y = c / grid_w;
        n = 0;
        if (x > 0) begin nb[n] = c - 1; dr[n] = rpm_pkg::DIR_LEFT; n++; end
        if (x + 1 < grid_w) begin nb[n] = c + 1; dr[n] = rpm_pkg::DIR_RIGHT; n++; end
        if (y > 0) begin nb[n] = c - grid_w; dr[n] = rpm_pkg::DIR_UP; n++; end
        if (y + 1 < grid_h) begin nb[n] = c + grid_w; dr[n] = rpm_pkg::DIR_DOWN; n++; end
        return n;
    endfunction

    function automatic t_carve carve_predict(logic kind, int unsigned pick,
                                             int unsigned link);
        t_carve r;
        int unsigned nb[4], cand[4], n, nc, idx, c, k;
        logic [1:0] dr[4], cdir[4];
        r = '0;
        nc = 0;
        if (kind == rpm_pkg::KIND_START) begin
            grid_w = side_clamp(reg_w);
            grid_h = side_clamp(reg_h);
            if (grid_w * grid_h > NCELL) grid_h = NCELL / grid_w;
            foreach (maze_bit[i]) maze_bit[i] = 1'b0;
            front_len = 0;
            c = pick % (grid_w * grid_h);
            maze_bit[c] = 1'b1;
            n = nbrs(c, nb, dr);
            for (int unsigned i = 0; i < n; i++) begin
                front[front_len] = nb[i];
                front_len++;
            end
            r.from_cell = rpm_pkg::OUT_CELL_W'(c);
            r.is_start = 1'b1;
            r.last = (front_len == 0);
            return r;
        end
        if (front_len == 0) begin
            r.last = 1'b1;
            r.error = 1'b1;
            return r;
        end
        idx = pick % front_len;
        c = front[idx];
        n = nbrs(c, nb, dr);
        for (int unsigned i = 0; i < n; i++) begin
            if (maze_bit[nb[i]]) begin
                cand[nc] = nb[i]; cdir[nc] = dr[i]; nc++;
            end else if (!on_front(nb[i]) && front_len < NCELL) begin
                front[front_len] = nb[i];
                front_len++;
            end
        end
        r.from_cell = rpm_pkg::OUT_CELL_W'(c);
        if (nc > 0) begin
            k = link % nc;
            r.to_cell = rpm_pkg::OUT_CELL_W'(cand[k]);
            r.direction = cdir[k];
        end else begin
            r.to_cell = rpm_pkg::OUT_CELL_W'(c);
        end
        maze_bit[c] = 1'b1;
        for (int unsigned i = idx; i + 1 < front_len; i++) front[i] = front[i + 1];
        front_len--;
        r.last = (front_len == 0);
        return r;
    endfunction

    // receiver: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_carve got, exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_from_cell, o_to_cell, o_direction, o_is_start, o_last, o_error};
            if (carve_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected carve result %p", got);
            end else begin
                exp_r = carve_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("carve mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    // send one request, predicting its result when accepted; valid stays up
    // for a following request or until the next drain
    task automatic send_request(logic kind, int unsigned pick, int unsigned link);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_rand_pick <= pick[rpm_pkg::PICK_W-1:0];
        i_rand_link <= link[rpm_pkg::PICK_W-1:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        carve_q.push_back(carve_predict(kind, pick & 32'h7fff_ffff, link & 32'h7fff_ffff));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (carve_q.size() != 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
    endtask

    task automatic apb_write(logic addr_bit, int unsigned value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {addr_bit, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr_bit == rpm_pkg::REG_WIDTH) reg_w = value & 6'h3f;
        else reg_h = value & 6'h3f;
        @(posedge i_clk);
    endtask

    task automatic set_grid(int unsigned w, int unsigned h);
        wait_drain();
        apb_write(rpm_pkg::REG_WIDTH, w);
        apb_write(rpm_pkg::REG_HEIGHT, h);
    endtask

    // carve a maze with random picks until the frontier is empty or max_steps is reached
    task automatic carve_maze(int unsigned max_steps);
        send_request(rpm_pkg::KIND_START, $urandom, $urandom);
        for (int unsigned i = 0; i < max_steps && front_len != 0; i++)
            send_request(rpm_pkg::KIND_STEP, $urandom, $urandom);
    endtask

    task automatic test_directed();
        // step before any start, then extremes of the fields
        send_request(rpm_pkg::KIND_STEP, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(rpm_pkg::KIND_START, 0, 0);
        send_request(rpm_pkg::KIND_STEP, 32'h7fff_ffff, 0);
        send_request(rpm_pkg::KIND_STEP, 0, 32'h7fff_ffff);
        send_request(rpm_pkg::KIND_START, 32'h7fff_ffff, 32'h5555_5555);
        send_request(rpm_pkg::KIND_STEP, 32'h2aaa_aaaa, 32'h5555_5555);
        // one-cell grid, then a step with empty frontier
        set_grid(1, 1);
        send_request(rpm_pkg::KIND_START, 32'h1234_5678, 0);
        send_request(rpm_pkg::KIND_STEP, 5, 5);
        // zero sizes, oversize sizes
        set_grid(0, 0);
        send_request(rpm_pkg::KIND_START, 3, 3);
        set_grid(63, 63);
        send_request(rpm_pkg::KIND_START, 32'h7fff_ffff, 1);
        send_request(rpm_pkg::KIND_STEP, 7, 2);
        // single row and single column carved fully
        set_grid(5, 1);
        carve_maze(10);
        send_request(rpm_pkg::KIND_STEP, 1, 1);
        set_grid(1, 4);
        carve_maze(10);
    endtask

    task automatic test_random(int unsigned n_items);
        int unsigned sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_request(1'($urandom_range(1)), $urandom, $urandom);
                sent++;
            end else begin
                // mostly small grids, a full-size one now and then
                if ($urandom_range(19) == 0) set_grid(32, 32);
                else set_grid($urandom_range(1, 6), $urandom_range(1, 6));
                send_request(rpm_pkg::KIND_START, $urandom, $urandom);
                sent++;
                while (front_len != 0 && sent < n_items) begin
                    send_request(rpm_pkg::KIND_STEP, $urandom, $urandom);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        wait_drain();
        hold_off = 3000;
        set_grid(3, 3);
        carve_maze(12);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 0;  stall_pct = 0;  test_random(100);
        send_idle_pct = 55; stall_pct = 0;  test_random(100);
        send_idle_pct = 0;  stall_pct = 55; test_random(100);
        send_idle_pct = 21; stall_pct = 21; test_random(150);
        test_backpressure();
        wait_drain();
        if (mismatches == 0 && carve_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
hdl/rpm_pkg.sv
hdl/rpm_ram.sv
hdl/rpm_div.sv
hdl/random_prim_maze_carver.sv
hdl/rpm_checker.sv
verif/tb.sv
